/* hdl/nfsa_pkg.sv */
// Package for the next-fit slot allocator.
// Holds the operation codes, bitmap word geometry, sequencer state type and the
// lowest-set-bit encoder. No dependencies.
package nfsa_pkg;

    localparam int FUNC_W        = 2;
    localparam int SLOT_IO_W     = 10;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;
    localparam int NUM_SLOTS_DEF = 1024;

    localparam logic [FUNC_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] OP_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] OP_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ACCESS,
        ST_FINISH
    } nfsa_state_t;

    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] iso;
        logic [BIT_W-1:0]  idx;
        iso = v & (~v + WORD_W'(1));
        idx = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (iso[i])
            begin
                idx = idx | BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* hdl/nfsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the slot busy bitmap. No dependencies.
module nfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/next_fit_slot_allocator_core.sv */
// Next-fit slot allocator: top level with the bitmap scan sequencer.
// Depends on nfsa_pkg and nfsa_ram.
//
// The busy bitmap sits in one RAM of 32-bit words (NUM_SLOTS/32 rounded up words),
// and a single read port feeds one word per cycle to the free-bit search unit in a scan.
// After reset a clearing pass writes every bitmap word to zero, one word per cycle,
// with in_stall high. An allocate scans from the word holding the slot after the
// last one given to the first free slot, sweeping the whole pool when it is full;
// free and query read the word of the given slot; an unused operation or a slot
// beyond the pool goes straight to the result. One transaction is worked at a time,
// and the result waits in an output register so the next transaction can start.
module next_fit_slot_allocator_core #(
    parameter int NUM_SLOTS = nfsa_pkg::NUM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [nfsa_pkg::FUNC_W-1:0]     func,
    input  logic [nfsa_pkg::SLOT_IO_W-1:0]  slot_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [nfsa_pkg::SLOT_IO_W-1:0]  slot_out,
    output logic                            busy_res,
    output logic                            status
);

    import nfsa_pkg::*;

    localparam int NUM_WORDS  = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SLOT_EXT_W = WIDX_W + BIT_W;
    localparam int K_W        = $clog2(NUM_WORDS + 1);
    localparam int REM        = NUM_SLOTS % WORD_W;
    localparam logic [WORD_W-1:0] LAST_MASK =
        (REM == 0) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << REM) - 64'd1);

    nfsa_state_t          state_reg, state_next;
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [SLOT_IO_W-1:0] slot_reg, slot_next;
    logic [WIDX_W-1:0]    word_ptr_reg, word_ptr_next;
    logic [K_W-1:0]       pass_reg, pass_next;
    logic [WIDX_W-1:0]    clr_reg, clr_next;
    logic [WORD_W-1:0]    res_word_reg, res_word_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [WIDX_W-1:0]    wr_addr_reg, wr_addr_next;
    logic [SLOT_IO_W-1:0] res_slot_reg, res_slot_next;
    logic                 res_busy_reg, res_busy_next;
    logic                 res_status_reg, res_status_next;
    logic                 lg_upd_reg, lg_upd_next;
    logic [SLOT_W-1:0]    new_lg_reg, new_lg_next;
    logic [SLOT_W-1:0]    last_given_reg, last_given_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_IO_W-1:0] slot_out_reg, slot_out_next;
    logic                 busy_res_reg, busy_res_next;
    logic                 status_reg, status_next;

    logic                  ram_we;
    logic [WIDX_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [WIDX_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    logic                  in_accept;
    logic                  out_free;
    logic                  in_range;
    logic [SLOT_EXT_W-1:0] in_ext;
    logic [SLOT_EXT_W-1:0] req_ext;
    logic [SLOT_EXT_W-1:0] start_ext;
    logic [BIT_W-1:0]      start_bit;
    logic [WORD_W-1:0]     lo_mask;
    logic [WORD_W-1:0]     valid_mask;
    logic [WORD_W-1:0]     pass_mask;
    logic [WORD_W-1:0]     avail;
    logic [BIT_W-1:0]      hit_bit;
    logic [SLOT_EXT_W-1:0] hit_ext;
    logic [WIDX_W-1:0]     word_ptr_inc;
    logic [BIT_W-1:0]      req_bit;

    nfsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign slot_out  = slot_out_reg;
    assign busy_res  = busy_res_reg;
    assign status    = status_reg;

    assign in_range  = (32'(slot_in) < NUM_SLOTS);
    assign in_ext    = SLOT_EXT_W'(slot_in);
    assign req_ext   = SLOT_EXT_W'(slot_reg);
    assign req_bit   = req_ext[BIT_W-1:0];
    assign start_ext = (last_given_reg == SLOT_W'(NUM_SLOTS - 1)) ? '0
                     : SLOT_EXT_W'(last_given_reg) + SLOT_EXT_W'(1);
    assign start_bit = start_ext[BIT_W-1:0];
    assign lo_mask   = (WORD_W'(1) << start_bit) - WORD_W'(1);

    assign valid_mask = (word_ptr_reg == WIDX_W'(NUM_WORDS - 1)) ? LAST_MASK : '1;

    always_comb
    begin
        if (pass_reg == '0)
        begin
            pass_mask = ~lo_mask;
        end
        else if (pass_reg == K_W'(NUM_WORDS))
        begin
            pass_mask = lo_mask;
        end
        else
        begin
            pass_mask = '1;
        end
    end

    assign avail        = ~ram_rdata & valid_mask & pass_mask;
    assign hit_bit      = first_set(avail);
    assign hit_ext      = {word_ptr_reg, hit_bit};
    assign word_ptr_inc = (word_ptr_reg == WIDX_W'(NUM_WORDS - 1)) ? '0
                        : word_ptr_reg + WIDX_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        slot_next       = slot_reg;
        word_ptr_next   = word_ptr_reg;
        pass_next       = pass_reg;
        clr_next        = clr_reg;
        res_word_next   = res_word_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        res_slot_next   = res_slot_reg;
        res_busy_next   = res_busy_reg;
        res_status_next = res_status_reg;
        lg_upd_next     = lg_upd_reg;
        new_lg_next     = new_lg_reg;
        last_given_next = last_given_reg;
        out_valid_next  = out_valid_reg && out_stall;
        slot_out_next   = slot_out_reg;
        busy_res_next   = busy_res_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_addr_reg;
        ram_wdata       = res_word_reg;
        ram_raddr       = word_ptr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == WIDX_W'(NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + WIDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    func_next       = func;
                    slot_next       = slot_in;
                    wr_pend_next    = 1'b0;
                    lg_upd_next     = 1'b0;
                    res_slot_next   = slot_in;
                    res_busy_next   = 1'b0;
                    res_status_next = 1'b0;
                    if (func == OP_ALLOC)
                    begin
                        word_ptr_next = start_ext[SLOT_EXT_W-1:BIT_W];
                        pass_next     = '0;
                        ram_raddr     = start_ext[SLOT_EXT_W-1:BIT_W];
                        state_next    = ST_SCAN;
                    end
                    else if ((func == OP_FREE || func == OP_QUERY) && in_range)
                    begin
                        wr_addr_next = in_ext[SLOT_EXT_W-1:BIT_W];
                        ram_raddr    = in_ext[SLOT_EXT_W-1:BIT_W];
                        state_next   = ST_ACCESS;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                if (|avail)
                begin
                    res_word_next   = ram_rdata | (WORD_W'(1) << hit_bit);
                    wr_pend_next    = 1'b1;
                    wr_addr_next    = word_ptr_reg;
                    res_slot_next   = SLOT_IO_W'(hit_ext);
                    res_busy_next   = 1'b1;
                    res_status_next = 1'b0;
                    lg_upd_next     = 1'b1;
                    new_lg_next     = SLOT_W'(hit_ext);
                    state_next      = ST_FINISH;
                end
                else if (pass_reg == K_W'(NUM_WORDS))
                begin
                    res_slot_next   = '0;
                    res_busy_next   = 1'b0;
                    res_status_next = 1'b1;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    word_ptr_next = word_ptr_inc;
                    pass_next     = pass_reg + K_W'(1);
                    ram_raddr     = word_ptr_inc;
                end
            end

            ST_ACCESS:
            begin
                if (func_reg == OP_FREE)
                begin
                    res_word_next = ram_rdata & ~(WORD_W'(1) << req_bit);
                    wr_pend_next  = 1'b1;
                    res_busy_next = 1'b0;
                end
                else
                begin
                    res_busy_next = ram_rdata[req_bit];
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    ram_we         = wr_pend_reg;
                    out_valid_next = 1'b1;
                    slot_out_next  = res_slot_reg;
                    busy_res_next  = res_busy_reg;
                    status_next    = res_status_reg;
                    if (lg_upd_reg)
                    begin
                        last_given_next = new_lg_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            last_given_reg <= SLOT_W'(NUM_SLOTS - 1);
            out_valid_reg  <= 1'b0;
            wr_pend_reg    <= 1'b0;
            lg_upd_reg     <= 1'b0;
            pass_reg       <= '0;
            word_ptr_reg   <= '0;
            func_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            last_given_reg <= last_given_next;
            out_valid_reg  <= out_valid_next;
            wr_pend_reg    <= wr_pend_next;
            lg_upd_reg     <= lg_upd_next;
            pass_reg       <= pass_next;
            word_ptr_reg   <= word_ptr_next;
            func_reg       <= func_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        res_word_reg   <= res_word_next;
        wr_addr_reg    <= wr_addr_next;
        res_slot_reg   <= res_slot_next;
        res_busy_reg   <= res_busy_next;
        res_status_reg <= res_status_next;
        new_lg_reg     <= new_lg_next;
        slot_out_reg   <= slot_out_next;
        busy_res_reg   <= busy_res_next;
        status_reg     <= status_next;
    end

endmodule
